// ----- design/tksvl_pkg.sv -----
// ----------------------------------------------------------------------------
// tksvl_pkg
// Shared types and constants for the top-K sorted violation list.
// ----------------------------------------------------------------------------
package tksvl_pkg;

    // Number of entries held in the list.
    localparam int LIST_DEPTH = 16;
    // Width of a count that can hold LIST_DEPTH itself.
    localparam int COUNT_W = $clog2(LIST_DEPTH + 1);

    // Fixed field widths of the item ports.
    localparam int KIND_W   = 2;
    localparam int VIO_W    = 32;
    localparam int TAG_W    = 16;
    localparam int RIDX_W   = 4;
    localparam int POS_W    = 4;
    localparam int ECOUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_OFFER = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input item
        logic exec;     // perform the operation and load the result registers
    } dp_cmd_t;

endpackage

// ----- design/tksvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tksvl_ctrl
// Controller: sequences capture and execution of each item and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module tksvl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tksvl_pkg::dp_cmd_t cmd
);
    import tksvl_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result register must be free, or be emptied this cycle.
                if (!out_valid_reg || m_ready) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// ----- design/tksvl_dp.sv -----
// ----------------------------------------------------------------------------
// tksvl_dp
// Datapath: a row of list cells that compare against the offered violation
// in parallel and shift down on insertion, plus the item and result
// registers.
// ----------------------------------------------------------------------------
module tksvl_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tksvl_pkg::dp_cmd_t                    cmd,
    input  logic [tksvl_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [tksvl_pkg::VIO_W-1:0]    s_violation,
    input  logic [tksvl_pkg::TAG_W-1:0]           s_entry_tag,
    input  logic [tksvl_pkg::RIDX_W-1:0]          s_read_index,
    output logic                                  m_accepted,
    output logic [tksvl_pkg::POS_W-1:0]           m_position,
    output logic [tksvl_pkg::ECOUNT_W-1:0]        m_entry_count,
    output logic signed [tksvl_pkg::VIO_W-1:0]    m_read_violation,
    output logic [tksvl_pkg::TAG_W-1:0]           m_read_tag
);
    import tksvl_pkg::*;

    // Captured item.
    logic [KIND_W-1:0]        kind_reg;
    logic signed [VIO_W-1:0]  vio_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic [RIDX_W-1:0]        ridx_reg;

    // List cells.
    logic signed [VIO_W-1:0]  value_reg [LIST_DEPTH];
    logic [TAG_W-1:0]         etag_reg  [LIST_DEPTH];
    logic signed [VIO_W-1:0]  value_next [LIST_DEPTH];
    logic [TAG_W-1:0]         etag_next  [LIST_DEPTH];
    logic [COUNT_W-1:0]       count_reg, count_next;

    // Result registers.
    logic                     acc_reg, acc_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [VIO_W-1:0]  rvio_reg, rvio_next;
    logic [TAG_W-1:0]         rtag_reg, rtag_next;

    logic [LIST_DEPTH-1:0]    beats;
    logic [COUNT_W-1:0]       ins_pos;
    logic                     ins_ok;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            vio_reg  <= s_violation;
            tag_reg  <= s_entry_tag;
            ridx_reg <= s_read_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                value_reg[i] <= value_next[i];
                etag_reg[i]  <= etag_next[i];
            end
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            rvio_reg <= rvio_next;
            rtag_reg <= rtag_next;
        end
    end

    // Each valid cell reports whether the offer beats its stored violation.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            beats[i] = (vio_reg > value_reg[i]) && (COUNT_W'(i) < count_reg);
        end
    end

    // First beaten cell wins; with none, the offer goes after the last entry.
    always_comb begin
        ins_pos = count_reg;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (beats[i]) begin
                ins_pos = COUNT_W'(i);
            end
        end
        ins_ok = (ins_pos < COUNT_W'(LIST_DEPTH));
    end

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            value_next[i] = value_reg[i];
            etag_next[i]  = etag_reg[i];
        end
        count_next = count_reg;
        acc_next   = 1'b0;
        pos_next   = '0;
        rvio_next  = '0;
        rtag_next  = '0;

        unique case (kind_t'(kind_reg))
            KIND_OFFER: begin
                if (ins_ok) begin
                    if (ins_pos == '0) begin
                        value_next[0] = vio_reg;
                        etag_next[0]  = tag_reg;
                    end
                    for (int i = 1; i < LIST_DEPTH; i++) begin
                        if (COUNT_W'(i) == ins_pos) begin
                            value_next[i] = vio_reg;
                            etag_next[i]  = tag_reg;
                        end else if (COUNT_W'(i) > ins_pos) begin
                            value_next[i] = value_reg[i-1];
                            etag_next[i]  = etag_reg[i-1];
                        end
                    end
                    if (count_reg < COUNT_W'(LIST_DEPTH)) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    acc_next = 1'b1;
                    pos_next = POS_W'(ins_pos);
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
            end
            KIND_READ: begin
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if ((int'(ridx_reg) == i) && (COUNT_W'(i) < count_reg)) begin
                        rvio_next = value_reg[i];
                        rtag_next = etag_reg[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_accepted       = acc_reg;
    assign m_position       = pos_reg;
    assign m_entry_count    = ECOUNT_W'(count_reg);
    assign m_read_violation = rvio_reg;
    assign m_read_tag       = rtag_reg;

endmodule

// ----- design/top_k_sorted_violation_list.sv -----
// A result enters the output register in the execute state after its item is captured,
// once that register is free. Each item is captured, then executed, with all list cells
// comparing and shifting together; no new item is taken until the execute state is done.
// The next item is taken while a finished result waits in the output register.
// Reset (aresetn, synchronous, active low) empties the list and both channels.
// ----------------------------------------------------------------------------
// top_k_sorted_violation_list
// Keeps the best LIST_DEPTH candidates in descending order of violation,
// with offer, clear and read operations.
// ----------------------------------------------------------------------------
module top_k_sorted_violation_list (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tksvl_pkg::KIND_W-1:0]          s_kind,
    input  logic signed [tksvl_pkg::VIO_W-1:0]    s_violation,
    input  logic [tksvl_pkg::TAG_W-1:0]           s_entry_tag,
    input  logic [tksvl_pkg::RIDX_W-1:0]          s_read_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_accepted,
    output logic [tksvl_pkg::POS_W-1:0]           m_position,
    output logic [tksvl_pkg::ECOUNT_W-1:0]        m_entry_count,
    output logic signed [tksvl_pkg::VIO_W-1:0]    m_read_violation,
    output logic [tksvl_pkg::TAG_W-1:0]           m_read_tag
);
    import tksvl_pkg::*;

    dp_cmd_t cmd;

    tksvl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tksvl_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_kind           (s_kind),
        .s_violation      (s_violation),
        .s_entry_tag      (s_entry_tag),
        .s_read_index     (s_read_index),
        .m_accepted       (m_accepted),
        .m_position       (m_position),
        .m_entry_count    (m_entry_count),
        .m_read_violation (m_read_violation),
        .m_read_tag       (m_read_tag)
    );

endmodule

// ----- bench/top_k_sorted_violation_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_sorted_violation_list_tb
// Self-checking bench for the top-K sorted violation list. A directed table
// covers the extremes, ties, a full list and the unused kind. Random offers,
// reads, clears and unused kinds follow, checked against a behavioural copy of the list,
// with bursty input traffic and a stalling result consumer.
// ----------------------------------------------------------------------------
module top_k_sorted_violation_list_tb;
    import tksvl_pkg::*;

    localparam int RANDOM_ITEMS   = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    typedef struct packed {
        kind_t                    kind;
        logic signed [VIO_W-1:0]  violation;
        logic [TAG_W-1:0]         tag;
        logic [RIDX_W-1:0]        read_index;
    } list_item_t;

    typedef struct packed {
        logic                     accepted;
        logic [POS_W-1:0]         position;
        logic [ECOUNT_W-1:0]      entry_count;
        logic signed [VIO_W-1:0]  read_violation;
        logic [TAG_W-1:0]         read_tag;
    } list_result_t;

    typedef struct {
        list_item_t   item;
        int           reps;
        bit           typed;
        list_result_t want;
    } stim_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind;
    logic signed [VIO_W-1:0]  s_violation;
    logic [TAG_W-1:0]         s_entry_tag;
    logic [RIDX_W-1:0]        s_read_index;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_accepted;
    logic [POS_W-1:0]         m_position;
    logic [ECOUNT_W-1:0]      m_entry_count;
    logic signed [VIO_W-1:0]  m_read_violation;
    logic [TAG_W-1:0]         m_read_tag;

    // Behavioural copy of the list contents.
    logic signed [VIO_W-1:0]  held_vio [LIST_DEPTH];
    logic [TAG_W-1:0]         held_tag [LIST_DEPTH];
    int                       held_count = 0;

    list_result_t             predicted_results[$];
    stim_row_t                directed_rows[$];
    int                       mismatch_count = 0;
    int                       quiet_cycles = 0;
    int                       burst_left = 0;
    int unsigned              rx_cycle = 0;

    top_k_sorted_violation_list u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_violation      (s_violation),
        .s_entry_tag      (s_entry_tag),
        .s_read_index     (s_read_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_position       (m_position),
        .m_entry_count    (m_entry_count),
        .m_read_violation (m_read_violation),
        .m_read_tag       (m_read_tag)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Applies one item to the list copy and returns the result it should give.
    task automatic track_list_op(input list_item_t it, output list_result_t r);
        int  slot;
        bit  found;
        r = '0;
        case (it.kind)
            KIND_OFFER: begin
                slot  = held_count;
                found = 1'b0;
                // Strictly greater, so an equal violation lands behind the old one.
                for (int i = 0; i < held_count; i++) begin
                    if (!found && $signed(it.violation) > $signed(held_vio[i])) begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (slot < LIST_DEPTH) begin
                    for (int i = LIST_DEPTH - 1; i > slot; i--) begin
                        held_vio[i] = held_vio[i-1];
                        held_tag[i] = held_tag[i-1];
                    end
                    held_vio[slot] = it.violation;
                    held_tag[slot] = it.tag;
                    if (held_count < LIST_DEPTH)
                        held_count++;
                    r.accepted = 1'b1;
                    r.position = POS_W'(slot);
                end
            end
            KIND_CLEAR: begin
                held_count = 0;
            end
            KIND_READ: begin
                if (it.read_index < held_count) begin
                    r.read_violation = held_vio[it.read_index];
                    r.read_tag       = held_tag[it.read_index];
                end
            end
            default: ;
        endcase
        r.entry_count = ECOUNT_W'(held_count);
    endtask

    function automatic list_result_t outcome(int acc, int pos, int cnt, int rv, int rt);
        list_result_t r;
        r.accepted       = 1'(acc);
        r.position       = POS_W'(pos);
        r.entry_count    = ECOUNT_W'(cnt);
        r.read_violation = VIO_W'(rv);
        r.read_tag       = TAG_W'(rt);
        return r;
    endfunction

    function automatic stim_row_t stim_row(kind_t k, logic [VIO_W-1:0] v,
                                           logic [TAG_W-1:0] t, logic [RIDX_W-1:0] ri,
                                           int reps, bit typed, list_result_t want);
        stim_row_t s;
        s.item.kind       = k;
        s.item.violation  = v;
        s.item.tag        = t;
        s.item.read_index = ri;
        s.reps            = reps;
        s.typed           = typed;
        s.want            = want;
        return s;
    endfunction

    task automatic add_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endtask

    function automatic list_item_t random_list_op();
        list_item_t it;
        int unsigned sel;
        sel               = $urandom_range(0, 99);
        it.violation      = $urandom;
        it.tag            = TAG_W'($urandom);
        it.read_index     = RIDX_W'($urandom_range(0, 15));
        if (sel < 3)
            it.kind = KIND_CLEAR;
        else if (sel < 6)
            it.kind = KIND_NONE;
        else if (sel < 30)
            it.kind = KIND_READ;
        else begin
            it.kind = KIND_OFFER;
            // A narrow set of whole values produces plenty of ties.
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 3))
                        0: it.violation = 32'sh7FFF_FFFF;
                        1: it.violation = 32'sh8000_0000;
                        2: it.violation = 32'sh0000_0000;
                        default: it.violation = 32'shFFFF_FFFF;
                    endcase
                end
                1, 2, 3: it.violation = (int'($urandom_range(0, 7)) - 4) * 65536;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic push_item(input list_item_t it, input bit typed, input list_result_t want);
        list_result_t pred;
        s_valid      <= 1'b1;
        s_kind       <= it.kind;
        s_violation  <= it.violation;
        s_entry_tag  <= it.tag;
        s_read_index <= it.read_index;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        track_list_op(it, pred);
        predicted_results = {predicted_results, (typed ? want : pred)};
    endtask

    // Bursts of random length, separated by short gaps or by none at all.
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = 40;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 6);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // The receiver cycles through always ready, mostly ready, a regular
    // stall pattern and long stalls.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 99) < 70);
            2'd2: m_ready <= (rx_cycle[1:0] != 2'b11);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result with no item outstanding, actual %h", $time,
                         {m_accepted, m_position, m_entry_count, m_read_violation,
                          m_read_tag});
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(m_accepted));
                check_field("position", 32'(want.position), 32'(m_position));
                check_field("entry_count", 32'(want.entry_count), 32'(m_entry_count));
                check_field("read_violation", want.read_violation, m_read_violation);
                check_field("read_tag", 32'(want.read_tag), 32'(m_read_tag));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        list_item_t it;
        int         counted;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_kind       <= KIND_OFFER;
        s_violation  <= '0;
        s_entry_tag  <= '0;
        s_read_index <= '0;
        m_ready      <= 1'b0;

        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 0, 0, 0)));
        // The unused kind ignores every field, even with all bits set.
        add_row(stim_row(KIND_NONE, 32'h7FFF_FFFF, 16'hFFFF, 4'hF, 1, 1'b1,
                         outcome(0, 0, 0, 0, 0)));
        add_row(stim_row(KIND_OFFER, 32'h7FFF_FFFF, 16'hFFFF, 4'd0, 1, 1'b1,
                         outcome(1, 0, 1, 0, 0)));
        add_row(stim_row(KIND_OFFER, 32'h8000_0000, 16'h0000, 4'd0, 1, 1'b1,
                         outcome(1, 1, 2, 0, 0)));
        add_row(stim_row(KIND_OFFER, 32'h0000_0000, 16'h1234, 4'd0, 1, 1'b1,
                         outcome(1, 1, 3, 0, 0)));
        // An equal violation goes behind the existing entry.
        add_row(stim_row(KIND_OFFER, 32'h0000_0000, 16'h5678, 4'd0, 1, 1'b1,
                         outcome(1, 2, 4, 0, 0)));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 4, 32'h7FFF_FFFF, 16'hFFFF)));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd3, 1, 1'b1,
                         outcome(0, 0, 4, 32'h8000_0000, 16'h0000)));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd2, 1, 1'b0, '0));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd4, 1, 1'b1,
                         outcome(0, 0, 4, 0, 0)));
        add_row(stim_row(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 1, 1'b1,
                         outcome(0, 0, 4, 0, 0)));
        add_row(stim_row(KIND_CLEAR, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 0, 0, 0)));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 0, 0, 0)));
        // Sixteen equal offers fill the list; the tag counts up on each repeat.
        add_row(stim_row(KIND_OFFER, 32'hFFFF_0000, 16'h0100, 4'd0, 16, 1'b0, '0));
        // With the list full, a tie or a smaller violation has nowhere to go.
        add_row(stim_row(KIND_OFFER, 32'hFFFF_0000, 16'h0200, 4'd0, 1, 1'b1,
                         outcome(0, 0, 16, 0, 0)));
        add_row(stim_row(KIND_OFFER, 32'h8000_0000, 16'h0201, 4'd0, 1, 1'b1,
                         outcome(0, 0, 16, 0, 0)));
        add_row(stim_row(KIND_OFFER, 32'hFFFF_0001, 16'h0202, 4'd0, 1, 1'b1,
                         outcome(1, 0, 16, 0, 0)));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'hF, 1, 1'b0, '0));
        add_row(stim_row(KIND_READ, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 16, 32'hFFFF_0001, 16'h0202)));
        add_row(stim_row(KIND_CLEAR, 32'h0, 16'h0, 4'd0, 1, 1'b1,
                         outcome(0, 0, 0, 0, 0)));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                it     = directed_rows[r].item;
                it.tag = it.tag + TAG_W'(n);
                push_item(it, directed_rows[r].typed, directed_rows[r].want);
                pace_sender();
            end
        end
        drain_results();

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            it = random_list_op();
            push_item(it, 1'b0, '0);
            if (it.kind != KIND_NONE) begin
                counted++;
                if (counted == RANDOM_ITEMS / 2)
                    drain_results();
            end
            pace_sender();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tksvl_pkg.sv
design/tksvl_ctrl.sv
design/tksvl_dp.sv
design/top_k_sorted_violation_list.sv
bench/top_k_sorted_violation_list_tb.sv
